FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, register indexes and payload types of the streaming
// find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 4;
  localparam int OFFSET_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET       = 3'd4;

  // Input item: one text byte.
  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in;
  } in_item_t;

  // Result item: one output byte or a bare end marker.
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              has_char;
    logic              last_of_run;
    logic              end_of_text;
  } out_item_t;

  // Control shared by all window cells.
  typedef struct packed {
    logic update;
    logic shift;
  } window_ctrl_t;

  // Control shared by all result buffer cells.
  typedef struct packed {
    logic load;
    logic shift;
  } burst_ctrl_t;

endpackage

FILE: src/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: src/stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming substring replacement: replaces every leftmost, non-overlapping
// occurrence of the configured pattern by the configured replacement.
// ----------------------------------------------------------------------------
// Each item passes the input stage register and is then loaded into the
// result buffer. Throughput: one item per cycle while each item gives at
// most one result and the output is ready; an item with several results
// holds the result buffer until all of them have transferred.
// Reset: synchronous; clears the window fill, the offset counter, the buffer
// and the registers to their defaults. The window bytes are not cleared.
module stream_find_replace_core
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sfr_stream_if.sink             in_stream,
  sfr_stream_if.source           out_stream
);

  localparam int COUNT_W = $clog2(MAX_PATTERN + 1);
  localparam int BURST   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int BCW     = $clog2(BURST + 1);
  localparam logic [LEN_W-1:0] MAX_PLEN = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] MAX_RLEN = LEN_W'(MAX_REPLACEMENT);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_length;
  logic [OFFSET_W-1:0]   start_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      start_offset       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        REG_START_OFFSET:       start_offset       <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage register.
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;
  logic     out_xfer;
  logic [BCW-1:0] bcount;

  assign out_xfer        = out_stream.valid && out_stream.ready;
  assign advance         = stage_valid &&
                           ((bcount == '0) || ((bcount == BCW'(1)) && out_stream.ready));
  assign in_stream.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_stream.ready) begin
      stage_valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      stage_item <= in_stream.data;
    end
  end

  // Effective lengths saturate at the hardware limits.
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  assign plen = (pattern_length > MAX_PLEN) ? MAX_PLEN : pattern_length;
  assign rlen = (replacement_length > MAX_RLEN) ? MAX_RLEN : replacement_length;

  // Window state and match decision.
  logic [COUNT_W-1:0]  wcount;
  logic [COUNT_W-1:0]  cnt_next;
  logic [LEN_W-1:0]    cnt_next_ext;
  logic [OFFSET_W-1:0] bytes_seen;
  logic                enabled;
  logic                all_equal;
  logic                matched;
  logic                pop;
  logic [MAX_PATTERN-1:0] eq_vec;
  logic [MAX_PATTERN-1:0] cmp_vec;
  logic [CHAR_W-1:0]   wbyte [MAX_PATTERN];
  logic [CHAR_W-1:0]   wcur  [MAX_PATTERN];
  window_ctrl_t        wctrl;

  assign cnt_next     = wcount + COUNT_W'(1);
  assign cnt_next_ext = LEN_W'(cnt_next);
  assign enabled      = (bytes_seen >= start_offset) && (plen != '0);
  assign all_equal    = &(eq_vec | ~cmp_vec);
  assign matched      = enabled && (cnt_next_ext == plen) && all_equal;
  assign pop          = !enabled || (cnt_next_ext > plen) ||
                        ((cnt_next_ext == plen) && !all_equal);

  assign wctrl.update = advance;
  assign wctrl.shift  = pop;

  // Row of window cells, oldest byte in cell zero.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_window
    logic [CHAR_W-1:0] nbr;
    if (k == MAX_PATTERN - 1) begin : g_top
      assign nbr = wbyte[k];
    end else begin : g_mid
      assign nbr = wbyte[k+1];
    end
    assign cmp_vec[k] = (LEN_W'(k) < plen);

    sfr_window_cell #(
      .INDEX   (k),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk          (clk),
      .ctrl         (wctrl),
      .count        (wcount),
      .new_byte     (stage_item.char_in),
      .next_byte    (nbr),
      .pattern_byte (pattern_bytes[CHAR_W*k +: CHAR_W]),
      .cell_byte    (wbyte[k]),
      .cur_byte     (wcur[k]),
      .equal        (eq_vec[k])
    );
  end

  // Window fill and offset counter update on each processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      wcount     <= '0;
      bytes_seen <= '0;
    end else if (advance) begin
      if (stage_item.last_in) begin
        bytes_seen <= '0;
      end else if (bytes_seen < start_offset) begin
        bytes_seen <= bytes_seen + OFFSET_W'(1);
      end
      priority if (matched || stage_item.last_in) begin
        wcount <= '0;
      end else if (pop) begin
        wcount <= wcount;
      end else begin
        wcount <= cnt_next;
      end
    end
  end

  // Results of the item: the replacement, window bytes from the oldest, or a bare end marker.
  logic           bare_next;
  logic [BCW-1:0] load_count;

  assign bare_next = matched && stage_item.last_in && (rlen == '0);

  always_comb begin
    priority if (bare_next) begin
      load_count = BCW'(1);
    end else if (matched) begin
      load_count = BCW'(rlen);
    end else if (stage_item.last_in) begin
      load_count = BCW'(cnt_next);
    end else if (pop) begin
      load_count = BCW'(1);
    end else begin
      load_count = '0;
    end
  end

  // Result buffer: row of cells shifting toward the output slot.
  logic        bare;
  logic        eot;
  burst_ctrl_t bctrl;
  logic [CHAR_W-1:0] bbyte [BURST];

  assign bctrl.load  = advance;
  assign bctrl.shift = out_xfer && !advance;

  for (genvar k = 0; k < BURST; k++) begin : g_burst
    logic [CHAR_W-1:0] rep_byte;
    logic [CHAR_W-1:0] win_byte;
    logic [CHAR_W-1:0] nbr;
    if (k < MAX_REPLACEMENT) begin : g_rep
      assign rep_byte = replacement_bytes[CHAR_W*k +: CHAR_W];
    end else begin : g_norep
      assign rep_byte = '0;
    end
    if (k < MAX_PATTERN) begin : g_win
      assign win_byte = wcur[k];
    end else begin : g_nowin
      assign win_byte = '0;
    end
    if (k == BURST - 1) begin : g_top
      assign nbr = bbyte[k];
    end else begin : g_mid
      assign nbr = bbyte[k+1];
    end

    sfr_out_cell u_cell (
      .clk       (clk),
      .ctrl      (bctrl),
      .load_byte (matched ? rep_byte : win_byte),
      .next_byte (nbr),
      .cell_byte (bbyte[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcount <= '0;
    end else if (advance) begin
      bcount <= load_count;
    end else if (out_xfer) begin
      bcount <= bcount - BCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bare <= bare_next;
      eot  <= stage_item.last_in;
    end
  end

  // Output slot is cell zero of the buffer.
  assign out_stream.valid            = (bcount != '0);
  assign out_stream.data.char_out    = bare ? '0 : bbyte[0];
  assign out_stream.data.has_char    = !bare;
  assign out_stream.data.last_of_run = (bcount == BCW'(1));
  assign out_stream.data.end_of_text = (bcount == BCW'(1)) && eot;

endmodule

FILE: src/sfr_window_cell.sv
// ----------------------------------------------------------------------------
// sfr_window_cell
// One byte position of the delay window. It shows the byte that the position
// holds once the incoming byte is added, compares it with its pattern byte,
// and either keeps that byte or takes the one of its upper neighbor.
// ----------------------------------------------------------------------------
module sfr_window_cell
  import sfr_pkg::*;
#(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 4
) (
  input  logic               clk,
  input  window_ctrl_t       ctrl,
  input  logic [COUNT_W-1:0] count,
  input  logic [CHAR_W-1:0]  new_byte,
  input  logic [CHAR_W-1:0]  next_byte,
  input  logic [CHAR_W-1:0]  pattern_byte,
  output logic [CHAR_W-1:0]  cell_byte,
  output logic [CHAR_W-1:0]  cur_byte,
  output logic               equal
);

  logic              sel_this;
  logic              sel_next;
  logic [CHAR_W-1:0] cell_byte_next;

  // The incoming byte lands at the position equal to the current fill.
  assign sel_this = (count == COUNT_W'(INDEX));
  assign sel_next = (count == COUNT_W'(INDEX + 1));

  // Window content with the incoming byte in place, and its pattern compare.
  assign cur_byte = sel_this ? new_byte : cell_byte;
  assign equal    = (cur_byte == pattern_byte);

  // On a shift the cell takes its neighbor's view of the extended window.
  always_comb begin
    if (ctrl.shift) begin
      cell_byte_next = sel_next ? new_byte : next_byte;
    end else begin
      cell_byte_next = cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      cell_byte <= cell_byte_next;
    end
  end

endmodule

FILE: src/sfr_out_cell.sv
// ----------------------------------------------------------------------------
// sfr_out_cell
// One slot of the result buffer. It is loaded in parallel with the results
// of one item and moves toward the output slot on every output transfer without a load.
// ----------------------------------------------------------------------------
module sfr_out_cell
  import sfr_pkg::*;
(
  input  logic              clk,
  input  burst_ctrl_t       ctrl,
  input  logic [CHAR_W-1:0] load_byte,
  input  logic [CHAR_W-1:0] next_byte,
  output logic [CHAR_W-1:0] cell_byte
);

  // Parallel load wins over the shift toward the output.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cell_byte <= load_byte;
    end else if (ctrl.shift) begin
      cell_byte <= next_byte;
    end
  end

endmodule

FILE: src/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace result stream, bound to the top.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A bare end marker carries no byte and closes both the run and the text.
  a_bare_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_char |->
      (out_data.char_out == '0) && out_data.last_of_run && out_data.end_of_text)
    else $error("malformed bare end marker");

  // The end of the text is always the end of a run.
  a_eot_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_text |-> out_data.last_of_run)
    else $error("end of text without end of run");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_data  (out_stream.data)
);

FILE: bench/stream_find_replace_core_tb.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core_tb
// Self-checking bench for the streaming find-and-replace core. Text bytes are
// sent over the input stream while a behavioral copy of the window, offset
// counter and registers predicts every result. Each result transfer is then
// checked field by field against the oldest prediction. Directed texts cover
// the end marker, full-length and short texts, a zero pattern length, the
// start offset and register changes in the middle of a text. Random texts
// then run under three idling profiles.
// ----------------------------------------------------------------------------
module stream_find_replace_core_tb
  import sfr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX   = 8;
  localparam int REPLACE_MAX  = 8;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sfr_stream_if #(.data_t(in_item_t))  in_if ();
  sfr_stream_if #(.data_t(out_item_t)) out_if ();

  stream_find_replace_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Register copies and text state of the predictor.
  logic [CFG_DATA_W-1:0] pat_reg;
  logic [LEN_W-1:0]      pat_len_reg;
  logic [CFG_DATA_W-1:0] rep_reg;
  logic [LEN_W-1:0]      rep_len_reg;
  logic [OFFSET_W-1:0]   offset_reg;
  logic [CHAR_W-1:0]     window_q [WINDOW_MAX];
  int unsigned           window_fill;
  logic [OFFSET_W-1:0]   text_bytes_seen;

  out_item_t step_bytes[$];
  out_item_t predicted_text_q[$];

  int error_count;
  int send_gap_pct;
  int recv_stall_pct;
  int stall_cycles;

  // Appends one output byte to the results of the current step.
  function automatic void emit_text_byte(input logic [CHAR_W-1:0] b);
    step_bytes.push_back(out_item_t'{char_out: b, has_char: 1'b1,
                                     last_of_run: 1'b0, end_of_text: 1'b0});
  endfunction

  // Moves the oldest window byte to the output, if there is one.
  function automatic void emit_oldest_window_byte();
    if (window_fill == 0) begin
      return;
    end
    emit_text_byte(window_q[0]);
    for (int k = 1; k < window_fill && k < WINDOW_MAX; k++) begin
      window_q[k-1] = window_q[k];
    end
    window_fill--;
  endfunction

  // Works out the results of one accepted text byte and queues them.
  function automatic void predict_text_step(input logic [CHAR_W-1:0] c, input logic last);
    int unsigned pat_len;
    int unsigned rep_len;
    bit          matching_on;
    bit          hit;
    out_item_t   tail;
    step_bytes.delete();
    pat_len = (pat_len_reg > WINDOW_MAX) ? WINDOW_MAX : pat_len_reg;
    rep_len = (rep_len_reg > REPLACE_MAX) ? REPLACE_MAX : rep_len_reg;
    matching_on = (text_bytes_seen >= offset_reg) && (pat_len != 0);
    if (text_bytes_seen < offset_reg) begin
      text_bytes_seen++;
    end
    if (window_fill >= WINDOW_MAX) begin
      emit_oldest_window_byte();
    end
    window_q[window_fill] = c;
    window_fill++;

    // Match only once the window holds exactly one pattern length.
    if (step_bytes.size() == 0) begin
      if (!matching_on || window_fill > pat_len) begin
        emit_oldest_window_byte();
      end else if (window_fill == pat_len) begin
        hit = 1'b1;
        for (int k = 0; k < pat_len; k++) begin
          if (window_q[k] != pat_reg[8*k +: 8]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          for (int k = 0; k < rep_len; k++) begin
            emit_text_byte(rep_reg[8*k +: 8]);
          end
          window_fill = 0;
        end else begin
          emit_oldest_window_byte();
        end
      end
    end

    // The final byte flushes the window and marks the end of the text.
    if (last) begin
      while (window_fill > 0) begin
        emit_oldest_window_byte();
      end
      if (step_bytes.size() == 0) begin
        step_bytes.push_back(out_item_t'{char_out: '0, has_char: 1'b0,
                                         last_of_run: 1'b0, end_of_text: 1'b0});
      end
      tail = step_bytes.pop_back();
      tail.end_of_text = 1'b1;
      step_bytes.push_back(tail);
      window_fill = 0;
      text_bytes_seen = '0;
    end
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.last_of_run = 1'b1;
      step_bytes.push_back(tail);
    end
    foreach (step_bytes[i]) begin
      predicted_text_q.push_back(step_bytes[i]);
    end
  endfunction

  // Sends one text byte, with a random gap first, and predicts its results.
  task automatic send_text_byte(input logic [CHAR_W-1:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= in_item_t'{char_in: c, last_in: last};
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    predict_text_step(c, last);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic settle_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (predicted_text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and updates the predictor's copy.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PATTERN_BYTES:      pat_reg     = value;
      REG_PATTERN_LENGTH:     pat_len_reg = value[LEN_W-1:0];
      REG_REPLACEMENT_BYTES:  rep_reg     = value;
      REG_REPLACEMENT_LENGTH: rep_len_reg = value[LEN_W-1:0];
      REG_START_OFFSET:       offset_reg  = value[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // Byte source that favors values likely to form matches.
  function automatic logic [CHAR_W-1:0] pick_alphabet_byte();
    logic [CHAR_W-1:0] b;
    case ($urandom_range(4))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h61;
      3: b = 8'h62;
      default: b = CHAR_W'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Reset defaults: the end marker and deletion of a one-byte zero pattern.
  task automatic test_end_marker();
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  // Full-length pattern and replacement, then a short text that never fills.
  task automatic test_full_length_match();
    settle_idle();
    write_reg(REG_PATTERN_BYTES, 64'h00FF_6162_A55A_0180);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    write_reg(REG_REPLACEMENT_BYTES, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    for (int k = 0; k < WINDOW_MAX; k++) begin
      send_text_byte(pat_reg[8*k +: 8], k == WINDOW_MAX - 1);
    end
    for (int k = 0; k < 3; k++) begin
      send_text_byte(pat_reg[8*k +: 8], k == 2);
    end
  endtask

  // A pattern length of zero turns matching off.
  task automatic test_zero_pattern_length();
    settle_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'h01, 1'b1);
  endtask

  // Leading bytes inside the start offset pass through unmatched.
  task automatic test_start_offset();
    settle_idle();
    write_reg(REG_PATTERN_BYTES, 64'h61);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
    write_reg(REG_START_OFFSET, 64'd2);
    repeat (2) send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b1);
  endtask

  // Lowered pattern length and raised offset in the middle of a text, and
  // writes to indexes past the register list.
  task automatic test_midtext_changes();
    settle_idle();
    write_reg(REG_START_OFFSET, 64'd0);
    write_reg(REG_PATTERN_BYTES, 64'h63_6261);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);
    settle_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_text_byte(8'h63, 1'b0);
    settle_idle();
    write_reg(REG_START_OFFSET, 64'd10);
    send_text_byte(8'h64, 1'b0);
    settle_idle();
    for (int idx = REG_START_OFFSET + 1; idx < (1 << CFG_INDEX_W); idx++) begin
      write_reg(CFG_INDEX_W'(idx), '1);
    end
    send_text_byte(8'h65, 1'b1);
  endtask

  // Random register settings, including values above range and the largest
  // offset.
  task automatic randomize_setup();
    logic [CFG_DATA_W-1:0] pat;
    logic [CFG_DATA_W-1:0] offset;
    settle_idle();
    for (int k = 0; k < WINDOW_MAX; k++) begin
      pat[8*k +: 8] = pick_alphabet_byte();
    end
    write_reg(REG_PATTERN_BYTES, pat);
    case ($urandom_range(9))
      0: write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(9, 15)));
      1: write_reg(REG_PATTERN_LENGTH, 64'd0);
      default: write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(1, 8)));
    endcase
    write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    if ($urandom_range(7) == 0) begin
      write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'($urandom_range(9, 15)));
    end else begin
      write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'($urandom_range(0, 8)));
    end
    case ($urandom_range(9))
      6, 7: offset = CFG_DATA_W'($urandom_range(1, 6));
      8: offset = 64'hFFFF;
      9: offset = CFG_DATA_W'($urandom_range(0, 65535));
      default: offset = '0;
    endcase
    write_reg(REG_START_OFFSET, offset);
    if ($urandom_range(9) == 0) begin
      write_reg(CFG_INDEX_W'($urandom_range(REG_START_OFFSET + 1, (1 << CFG_INDEX_W) - 1)),
                {$urandom, $urandom});
    end
  endtask

  // Random texts in which half of the bytes follow the pattern, with noise mixed in.
  task automatic test_random_texts(input int n_bytes);
    int sent;
    int text_len;
    int pat_pos;
    int gen_len;
    logic [CHAR_W-1:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(3) == 0) begin
        randomize_setup();
      end
      text_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      pat_pos = 0;
      for (int i = 0; i < text_len; i++) begin
        gen_len = (pat_len_reg == 0) ? 1 : ((pat_len_reg > WINDOW_MAX) ? WINDOW_MAX : pat_len_reg);
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            b = pat_reg[8*pat_pos +: 8];
            pat_pos = (pat_pos + 1) % gen_len;
          end
          5, 6, 7: b = pick_alphabet_byte();
          default: b = CHAR_W'($urandom_range(255));
        endcase
        if (pat_pos >= gen_len || $urandom_range(15) == 0) begin
          pat_pos = 0;
        end
        // Occasional register change while a text is open.
        if (i != text_len - 1 && $urandom_range(24) == 0) begin
          settle_idle();
          if ($urandom_range(1) == 1) begin
            write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(1, 8)));
          end else begin
            write_reg(REG_START_OFFSET, CFG_DATA_W'($urandom_range(0, 20)));
          end
        end
        send_text_byte(b, i == text_len - 1);
        sent++;
      end
    end
  endtask

  // Random receiver stalls, changed at the falling edge.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (predicted_text_q.size() == 0) begin
        $error("unexpected result: char_out %0h has_char %0b", got.char_out, got.has_char);
        error_count++;
      end else begin
        want = predicted_text_q.pop_front();
        if (got.char_out !== want.char_out) begin
          $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
          error_count++;
        end
        if (got.has_char !== want.has_char) begin
          $error("has_char: expected %0b, got %0b", want.has_char, got.has_char);
          error_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
          error_count++;
        end
        if (got.end_of_text !== want.end_of_text) begin
          $error("end_of_text: expected %0b, got %0b", want.end_of_text, got.end_of_text);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    stall_cycles = 0;
    error_count  = 0;
    pat_reg         = '0;
    pat_len_reg     = LEN_W'(1);
    rep_reg         = '0;
    rep_len_reg     = '0;
    offset_reg      = '0;
    window_fill     = 0;
    text_bytes_seen = '0;
    send_gap_pct    = 13;
    recv_stall_pct  = 58;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_end_marker();
    test_full_length_match();
    test_zero_pattern_length();
    test_start_offset();
    test_midtext_changes();
    test_random_texts(112);

    send_gap_pct   = 58;
    recv_stall_pct = 13;
    test_random_texts(112);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_texts(112);

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
